[rtl/rdb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rdb_pkg;
    localparam int MAX_NODES  = 16;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = NODE_W + 1;
    localparam int CALL_SLOTS = 64;
    localparam int SLOT_W     = $clog2(CALL_SLOTS);
    localparam int FUNC_SLOTS = 256;
    localparam int FUNC_W     = $clog2(FUNC_SLOTS);
    localparam int RUN_W      = SLOT_W + 1;
    localparam int ID_W       = 64;
    localparam int RR_W       = 32;
    localparam int INF_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] OP_DISPATCH = 2'd0;
    localparam logic [1:0] OP_FINISH   = 2'd1;
    localparam logic [1:0] OP_ONLINE   = 2'd2;
    localparam logic [1:0] OP_OFFLINE  = 2'd3;

    localparam logic [1:0] MODE_RR     = 2'd0;
    localparam logic [1:0] MODE_LEAST  = 2'd1;
    localparam logic [1:0] MODE_RANDOM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_NODES   = 3'd1;
    localparam logic [2:0] ST_OVER_LIMIT = 3'd2;
    localparam logic [2:0] ST_CONSTRAINT = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;
    localparam logic [2:0] ST_IGNORED    = 3'd5;

    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
endpackage
`default_nettype wire

[rtl/request_dispatch_balancer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  opcode, call_id, func_id, constraint_mask,
//                                         node_id, node_is_engine
// m_        out        m_valid / m_ready  status, picked_node
// cfg_      in         cfg_we             cfg_index, cfg_wdata
// one item at a time: online ends after the decode, offline compacts the node order
// list, finish scans the call table (one call-table ram read per slot), an accepted
// dispatch scans it too, then picks in round-robin or random mode (both use the serial
// modulo unit) or least in-flight mode; a rejected dispatch ends after the decode, the
// list build or the scan. after reset all 256 round-robin ram entries are cleared with s_ready low.
// a finished result sits in the output register and the next item may be taken meanwhile;
// the next result then waits until that register is free.
module request_dispatch_balancer_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_opcode,
    input  wire logic [63:0]                   s_call_id,
    input  wire logic [7:0]                    s_func_id,
    input  wire logic [15:0]                   s_constraint_mask,
    input  wire logic [3:0]                    s_node_id,
    input  wire logic                          s_node_is_engine,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_status,
    output logic [3:0]                         m_picked_node,
    input  wire logic                          cfg_we,
    input  wire logic [rdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rdb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    localparam int NW = rdb_pkg::NODE_W;
    localparam int CW = rdb_pkg::CNT_W;
    localparam int MN = rdb_pkg::MAX_NODES;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_LIST    = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_MODE    = 4'd5;
    localparam logic [3:0] S_RR_WAIT = 4'd6;
    localparam logic [3:0] S_MOD     = 4'd7;
    localparam logic [3:0] S_LEAST   = 4'd8;
    localparam logic [3:0] S_PICK    = 4'd9;
    localparam logic [3:0] S_COMPACT = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0] state_reg, state_next;

    logic [1:0]                  op_reg, op_next;
    logic [63:0]                 id_reg, id_next;
    logic [rdb_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [MN-1:0]               mask_reg, mask_next;
    logic [NW-1:0]               nid_reg, nid_next;
    logic                        eng_reg, eng_next;

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] limit_reg, limit_next;
    logic [31:0] lfsr_reg, lfsr_next;

    logic [MN-1:0]                  present_reg, present_next;
    logic [NW-1:0]                  order_reg [MN];
    logic [NW-1:0]                  order_next [MN];
    logic [CW-1:0]                  count_reg, count_next;
    logic [rdb_pkg::INF_W-1:0]      inflight_reg [MN];
    logic [rdb_pkg::INF_W-1:0]      inflight_next [MN];
    logic [rdb_pkg::CALL_SLOTS-1:0] valid_reg, valid_next;
    logic [rdb_pkg::RUN_W-1:0]      running_reg, running_next;

    logic [NW-1:0]             list_reg [MN];
    logic [NW-1:0]             list_next [MN];
    logic [CW-1:0]             n_reg, n_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [CW-1:0]             w_reg, w_next;
    logic [rdb_pkg::RUN_W-1:0] scan_reg, scan_next;
    logic                      pend_reg, pend_next;
    logic [rdb_pkg::SLOT_W-1:0] pidx_reg, pidx_next;
    logic                      found_reg, found_next;
    logic [rdb_pkg::SLOT_W-1:0] fidx_reg, fidx_next;
    logic                      free_reg, free_next;
    logic [rdb_pkg::SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic [NW-1:0]             idx_reg, idx_next;
    logic [rdb_pkg::INF_W-1:0] best_reg, best_next;
    logic [2:0]                status_reg, status_next;
    logic [NW-1:0]             picked_reg, picked_next;
    logic [rdb_pkg::FUNC_W:0]  clr_reg, clr_next;

    logic       mvalid_reg, mvalid_next;
    logic [2:0] mstatus_reg, mstatus_next;
    logic [NW-1:0] mpicked_reg, mpicked_next;

    logic                       ct_we;
    logic [rdb_pkg::SLOT_W-1:0] ct_waddr;
    logic [63:0]                ct_rdata;
    logic                       rr_we;
    logic [rdb_pkg::FUNC_W-1:0] rr_waddr;
    logic [31:0]                rr_wdata, rr_rdata;

    logic        mod_start, mod_done;
    logic [31:0] mod_dividend;
    logic [NW-1:0] mod_rem;
    logic [31:0] lfsr_step;
    logic [20:0] limit_total;
    logic [rdb_pkg::INF_W-1:0] cand;
    logic [NW-1:0] pnode;

    rdb_ram #(.WIDTH(64), .DEPTH(rdb_pkg::CALL_SLOTS)) u_call_ram (
        .aclk(aclk), .we(ct_we), .waddr(ct_waddr), .wdata(id_reg),
        .raddr(scan_reg[rdb_pkg::SLOT_W-1:0]), .rdata(ct_rdata)
    );

    rdb_ram #(.WIDTH(32), .DEPTH(rdb_pkg::FUNC_SLOTS)) u_rr_ram (
        .aclk(aclk), .we(rr_we), .waddr(rr_waddr), .wdata(rr_wdata),
        .raddr(func_reg), .rdata(rr_rdata)
    );

    rdb_mod u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start), .dividend(mod_dividend),
        .divisor(n_reg), .done(mod_done), .remainder(mod_rem)
    );

    assign lfsr_step    = lfsr_reg[0] ? ({1'b0, lfsr_reg[31:1]} ^ rdb_pkg::LFSR_MASK)
                                      : {1'b0, lfsr_reg[31:1]};
    assign mod_start    = (state_reg == S_RR_WAIT) ||
                          (state_reg == S_MODE && mode_reg != rdb_pkg::MODE_RR &&
                           mode_reg != rdb_pkg::MODE_LEAST);
    assign mod_dividend = (state_reg == S_RR_WAIT) ? rr_rdata : lfsr_step;
    assign limit_total  = {5'd0, limit_reg} * {{(21-CW){1'b0}}, count_reg};
    assign cand         = inflight_reg[list_reg[i_reg[NW-1:0]]];
    assign pnode        = list_reg[idx_reg];

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = mvalid_reg;
    assign m_status      = mstatus_reg;
    assign m_picked_node = mpicked_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        func_next     = func_reg;
        mask_next     = mask_reg;
        nid_next      = nid_reg;
        eng_next      = eng_reg;
        mode_next     = mode_reg;
        limit_next    = limit_reg;
        lfsr_next     = lfsr_reg;
        present_next  = present_reg;
        order_next    = order_reg;
        count_next    = count_reg;
        inflight_next = inflight_reg;
        valid_next    = valid_reg;
        running_next  = running_reg;
        list_next     = list_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        w_next        = w_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        status_next   = status_reg;
        picked_next   = picked_reg;
        clr_next      = clr_reg;
        mvalid_next   = mvalid_reg;
        mstatus_next  = mstatus_reg;
        mpicked_next  = mpicked_reg;
        ct_we         = 1'b0;
        ct_waddr      = free_idx_reg;
        rr_we         = 1'b0;
        rr_waddr      = func_reg;
        rr_wdata      = rr_rdata + 32'd1;

        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_index)
                rdb_pkg::REG_MODE:  mode_next  = cfg_wdata[1:0];
                rdb_pkg::REG_LIMIT: limit_next = cfg_wdata[15:0];
                rdb_pkg::REG_SEED:  lfsr_next  = (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR: begin
                rr_we    = 1'b1;
                rr_waddr = clr_reg[rdb_pkg::FUNC_W-1:0];
                rr_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (rdb_pkg::FUNC_W+1)'(rdb_pkg::FUNC_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    id_next    = s_call_id;
                    func_next  = s_func_id;
                    mask_next  = s_constraint_mask;
                    nid_next   = s_node_id;
                    eng_next   = s_node_is_engine;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                picked_next = '0;
                i_next      = '0;
                n_next      = '0;
                w_next      = '0;
                scan_next   = '0;
                pend_next   = 1'b0;
                found_next  = 1'b0;
                free_next   = 1'b0;
                state_next  = S_DONE;
                case (op_reg)
                    rdb_pkg::OP_DISPATCH: begin
                        if (count_reg == '0) begin
                            status_next = rdb_pkg::ST_NO_NODES;
                        end else if (limit_reg != '0 &&
                                     {14'd0, running_reg} > limit_total) begin
                            status_next = rdb_pkg::ST_OVER_LIMIT;
                        end else begin
                            state_next = S_LIST;
                        end
                    end
                    rdb_pkg::OP_FINISH: begin
                        state_next = S_SCAN;
                    end
                    rdb_pkg::OP_ONLINE: begin
                        if (eng_reg && !present_reg[nid_reg] &&
                            count_reg < CW'(MN)) begin
                            present_next[nid_reg]          = 1'b1;
                            order_next[count_reg[NW-1:0]]  = nid_reg;
                            count_next                     = count_reg + 1'b1;
                            inflight_next[nid_reg]         = '0;
                            status_next                    = rdb_pkg::ST_OK;
                        end else begin
                            status_next = rdb_pkg::ST_IGNORED;
                        end
                    end
                    default: begin
                        if (eng_reg && present_reg[nid_reg]) begin
                            present_next[nid_reg] = 1'b0;
                            state_next            = S_COMPACT;
                        end else begin
                            status_next = rdb_pkg::ST_IGNORED;
                        end
                    end
                endcase
            end
            S_LIST: begin
                if (i_reg[NW]) begin
                    if (n_reg == '0) begin
                        status_next = rdb_pkg::ST_CONSTRAINT;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end else begin
                    if (mask_reg != '0) begin
                        if (mask_reg[i_reg[NW-1:0]] && present_reg[i_reg[NW-1:0]]) begin
                            list_next[n_reg[NW-1:0]] = i_reg[NW-1:0];
                            n_next                   = n_reg + 1'b1;
                        end
                    end else if (i_reg < count_reg) begin
                        list_next[n_reg[NW-1:0]] = order_reg[i_reg[NW-1:0]];
                        n_next                   = n_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            S_SCAN: begin
                // compare the slot read last cycle, track the first free slot
                if (pend_reg && valid_reg[pidx_reg] && ct_rdata == id_reg) begin
                    found_next = 1'b1;
                    fidx_next  = pidx_reg;
                end
                pend_next = 1'b0;
                if (scan_reg != rdb_pkg::RUN_W'(rdb_pkg::CALL_SLOTS)) begin
                    pend_next = 1'b1;
                    pidx_next = scan_reg[rdb_pkg::SLOT_W-1:0];
                    scan_next = scan_reg + 1'b1;
                    if (!valid_reg[scan_reg[rdb_pkg::SLOT_W-1:0]] && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = scan_reg[rdb_pkg::SLOT_W-1:0];
                    end
                end else if (!pend_reg) begin
                    state_next = S_DONE;
                    if (op_reg == rdb_pkg::OP_FINISH) begin
                        if (found_reg) begin
                            valid_next[fidx_reg] = 1'b0;
                            running_next         = running_reg - 1'b1;
                            if (present_reg[nid_reg] && inflight_reg[nid_reg] != '0) begin
                                inflight_next[nid_reg] = inflight_reg[nid_reg] - 1'b1;
                            end
                            status_next = rdb_pkg::ST_OK;
                        end else begin
                            status_next = rdb_pkg::ST_IGNORED;
                        end
                    end else if (found_reg) begin
                        state_next = S_MODE;
                    end else if (free_reg) begin
                        ct_we                    = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        running_next             = running_reg + 1'b1;
                        state_next               = S_MODE;
                    end else begin
                        status_next = rdb_pkg::ST_TABLE_FULL;
                    end
                end
            end
            S_MODE: begin
                case (mode_reg)
                    rdb_pkg::MODE_RR: state_next = S_RR_WAIT;
                    rdb_pkg::MODE_LEAST: begin
                        idx_next   = '0;
                        best_next  = inflight_reg[list_reg[0]];
                        i_next     = CW'(1);
                        state_next = S_LEAST;
                    end
                    default: begin
                        lfsr_next  = lfsr_step;
                        state_next = S_MOD;
                    end
                endcase
            end
            S_RR_WAIT: begin
                rr_we      = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                if (mod_done) begin
                    idx_next   = mod_rem;
                    state_next = S_PICK;
                end
            end
            S_LEAST: begin
                if (i_reg < n_reg) begin
                    if (cand < best_reg) begin
                        best_next = cand;
                        idx_next  = i_reg[NW-1:0];
                    end
                    i_next = i_reg + 1'b1;
                end else begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                if (inflight_reg[pnode] != '1) begin
                    inflight_next[pnode] = inflight_reg[pnode] + 1'b1;
                end
                picked_next = pnode;
                status_next = rdb_pkg::ST_OK;
                state_next  = S_DONE;
            end
            S_COMPACT: begin
                if (i_reg < count_reg) begin
                    if (order_reg[i_reg[NW-1:0]] != nid_reg) begin
                        order_next[w_reg[NW-1:0]] = order_reg[i_reg[NW-1:0]];
                        w_next                    = w_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end else begin
                    for (int k = 0; k < MN; k++) begin
                        if (CW'(k) >= w_reg) begin
                            order_next[k] = '0;
                        end
                    end
                    count_next  = w_reg;
                    status_next = rdb_pkg::ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next  = 1'b1;
                    mstatus_next = status_reg;
                    mpicked_next = picked_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            mode_reg     <= rdb_pkg::MODE_RANDOM;
            limit_reg    <= '0;
            lfsr_reg     <= 32'd1;
            present_reg  <= '0;
            count_reg    <= '0;
            valid_reg    <= '0;
            running_reg  <= '0;
            mvalid_reg   <= 1'b0;
            for (int k = 0; k < MN; k++) begin
                order_reg[k]    <= '0;
                inflight_reg[k] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            mode_reg     <= mode_next;
            limit_reg    <= limit_next;
            lfsr_reg     <= lfsr_next;
            present_reg  <= present_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            running_reg  <= running_next;
            mvalid_reg   <= mvalid_next;
            order_reg    <= order_next;
            inflight_reg <= inflight_next;
        end
        op_reg       <= op_next;
        id_reg       <= id_next;
        func_reg     <= func_next;
        mask_reg     <= mask_next;
        nid_reg      <= nid_next;
        eng_reg      <= eng_next;
        list_reg     <= list_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        w_reg        <= w_next;
        scan_reg     <= scan_next;
        pend_reg     <= pend_next;
        pidx_reg     <= pidx_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        picked_reg   <= picked_next;
        mstatus_reg  <= mstatus_next;
        mpicked_reg  <= mpicked_next;
    end
endmodule
`default_nettype wire

[rtl/rdb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module rdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/rdb_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
// 32-bit value modulo a list size, one bit per cycle
module rdb_mod (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [31:0]               dividend,
    input  wire logic [rdb_pkg::CNT_W-1:0] divisor,
    output logic                           done,
    output logic [rdb_pkg::NODE_W-1:0]     remainder
);
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic [31:0]                 val_reg, val_next;
    logic [rdb_pkg::CNT_W-1:0]   div_reg, div_next;
    logic [rdb_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [rdb_pkg::CNT_W:0]     trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, val_reg[31]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            val_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[rdb_pkg::CNT_W-1:0];
            val_next = {val_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[rdb_pkg::NODE_W-1:0];
endmodule
`default_nettype wire

[rtl/rdb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module rdb_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_status,
    input wire logic [3:0] m_picked_node
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_picked_node))
        else $error("result changed while stalled");

    a_pick_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rdb_pkg::ST_OK |-> m_picked_node == 4'd0)
        else $error("picked node set on a non-ok result");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= rdb_pkg::ST_IGNORED)
        else $error("undefined status code");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");
endmodule

bind request_dispatch_balancer_core rdb_checker u_rdb_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_picked_node(m_picked_node)
);
`default_nettype wire
